FILE: rtl/hcsd_pkg.sv
// shared types, character codes and the hex digit helper for the chunked decoder
// no dependencies; imported by hcsd_step, hcsd_out_reg and the top module
package hcsd_pkg;

  localparam int DEF_COUNT_BITS = 32;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] HEX_TEN   = 8'd10;
  localparam logic [4:0] HEX_NONE  = 5'd16;

  typedef enum logic [4:0] {
    PH_SIZE    = 5'b00001,
    PH_LF_SIZE = 5'b00010,
    PH_DATA    = 5'b00100,
    PH_CR_DATA = 5'b01000,
    PH_LF_DATA = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    FIN_RUN = 2'd0,
    FIN_END = 2'd1,
    FIN_ERR = 2'd2
  } fin_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
  } result_t;

  // value of a hex digit, HEX_NONE for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      return t[4:0];
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + HEX_TEN;
      return t[4:0];
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      t = c - CH_LOW_A + HEX_TEN;
      return t[4:0];
    end
    return HEX_NONE;
  endfunction

endpackage

FILE: rtl/hcsd_byte_if.sv
// input channel: one body byte per word, valid/ready handshake
// depends on nothing
interface hcsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/hcsd_result_if.sv
// result channel: kind and payload byte per word, valid/ready handshake
// depends on nothing
interface hcsd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;

  modport source (output valid, output result_kind, output payload_byte, input ready);
  modport sink   (input valid, input result_kind, input payload_byte, output ready);
endinterface

FILE: rtl/hcsd_step.sv
// decoder state (phase, remaining count, sticky end/error) and per-byte classify
// depends on hcsd_pkg
module hcsd_step #(
  parameter int COUNT_BITS = hcsd_pkg::DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        in_byte,
  output hcsd_pkg::result_t res
);
  import hcsd_pkg::*;

  phase_t                phase_r, phase_nxt, phase_eff;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_dec;
  fin_t                  fin_r, fin_nxt;
  logic [4:0]            hv;
  logic                  cnt_zero;
  logic                  cnt_full;

  assign cnt_zero = (cnt_r == '0);
  assign cnt_full = (cnt_r[COUNT_BITS-1 -: 4] != 4'd0);
  assign cnt_dec  = cnt_r - COUNT_BITS'(1);
  assign hv       = hex_value(in_byte);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    res.kind    = KIND_FRAME;
    res.payload = 8'd0;
    phase_eff   = (phase_r == PH_DATA && cnt_zero) ? PH_CR_DATA : phase_r;
    if (fin_r == FIN_END) begin
      res.kind = KIND_END;
    end else if (fin_r != FIN_RUN) begin
      res.kind = KIND_ERR;
    end else begin
      unique case (phase_eff)
        PH_SIZE: begin
          if (in_byte == CH_CR) begin
            if (cnt_zero) begin
              fin_nxt  = FIN_END;
              res.kind = KIND_END;
            end else begin
              phase_nxt = PH_LF_SIZE;
            end
          end else if (hv[4] || cnt_full) begin
            fin_nxt  = FIN_ERR;
            res.kind = KIND_ERR;
          end else begin
            cnt_nxt = {cnt_r[COUNT_BITS-5:0], hv[3:0]};
          end
        end
        PH_LF_SIZE: begin
          if (in_byte == CH_LF) begin
            phase_nxt = PH_DATA;
          end else begin
            fin_nxt  = FIN_ERR;
            res.kind = KIND_ERR;
          end
        end
        PH_DATA: begin
          res.kind    = KIND_DATA;
          res.payload = in_byte;
          cnt_nxt     = cnt_dec;
          phase_nxt   = (cnt_dec == '0) ? PH_CR_DATA : PH_DATA;
        end
        PH_CR_DATA: begin
          if (in_byte == CH_CR) begin
            phase_nxt = PH_LF_DATA;
          end else begin
            fin_nxt  = FIN_ERR;
            res.kind = KIND_ERR;
          end
        end
        PH_LF_DATA: begin
          if (in_byte == CH_LF) begin
            phase_nxt = PH_SIZE;
          end else begin
            fin_nxt  = FIN_ERR;
            res.kind = KIND_ERR;
          end
        end
        default: begin
          fin_nxt  = FIN_ERR;
          res.kind = KIND_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      cnt_r   <= '0;
      fin_r   <= FIN_RUN;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r == FIN_END |=> fin_r == FIN_END)
    else $error("end flag dropped");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r == FIN_ERR |=> fin_r == FIN_ERR && $stable(phase_r) && $stable(cnt_r))
    else $error("state moved after error");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> cnt_r != '0)
    else $error("data phase with empty count");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    take && fin_r == FIN_RUN && phase_r == PH_DATA && !cnt_zero
    |=> cnt_r == $past(cnt_r) - COUNT_BITS'(1))
    else $error("payload byte did not step the count");
`endif

endmodule

FILE: rtl/hcsd_out_reg.sv
// result register: holds one word until the sink takes it, reloads on the same edge
// depends on hcsd_pkg and hcsd_result_if
module hcsd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hcsd_pkg::result_t res,
  output logic              load_ok,
  hcsd_result_if.source     out_ch
);
  import hcsd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // free when empty or when the held word leaves this edge
  assign load_ok = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ok) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.result_kind  = res_r.kind;
  assign out_ch.payload_byte = res_r.payload;

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && load_ok |=> out_ch.valid)
    else $error("loaded word not presented");
`endif

endmodule

FILE: rtl/http_chunked_stream_decoder_top.sv
// HTTP chunked body decoder: takes one body byte per word and returns one result
// word per byte (framing, payload, end, error). It accepts a byte every cycle and
// the result appears in the output register in the following cycle; the only limit on
// rate is the sink, since a new byte is taken whenever that register is empty or
// being read in the same cycle. Chunk extensions are rejected as errors, end and
// error are sticky until reset, and size values beyond COUNT_BITS bits are errors.
// depends on hcsd_pkg, hcsd_byte_if, hcsd_result_if, hcsd_step, hcsd_out_reg
module http_chunked_stream_decoder_top #(
  parameter int COUNT_BITS = hcsd_pkg::DEF_COUNT_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  hcsd_byte_if.sink     in_ch,
  hcsd_result_if.source out_ch
);
  import hcsd_pkg::*;

  logic    take;
  logic    load_ok;
  result_t res;

  assign in_ch.ready = load_ok;
  assign take        = in_ch.valid && load_ok;

  hcsd_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .in_byte(in_ch.in_byte),
    .res    (res)
  );

  hcsd_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take),
    .res    (res),
    .load_ok(load_ok),
    .out_ch (out_ch)
  );

endmodule
